// File: sv/vibration_noise_quake_detector_top_macros.svh
// Assertion helpers used by the detector controller (vnqd_ctrl).
// Each expects clk and arst_n in scope.
`ifndef VIBRATION_NOISE_QUAKE_DETECTOR_TOP_MACROS_SVH
`define VIBRATION_NOISE_QUAKE_DETECTOR_TOP_MACROS_SVH

// same-cycle implication
`define VNQD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vnqd assertion failed");

// next-cycle implication
`define VNQD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vnqd assertion failed");

`endif

// File: sv/vnqd_pkg.sv
package vnqd_pkg;

	// jolt timestamp ring
	localparam int JOLT_SLOTS = 16;
	localparam int RING_AW    = $clog2(JOLT_SLOTS);
	localparam int CNT_W      = $clog2(JOLT_SLOTS + 1);

	// Q.8 baselines
	localparam int BASE_W = 24;

	// divide-by-5 by reciprocal multiply: q = (x * ceil(2^29 / 5)) >> 29,
	// exact for every 27-bit dividend
	localparam int               DIV_W     = 27;
	localparam int               DIV_SHIFT = 29;
	localparam logic [DIV_W-1:0] DIV_RECIP = 27'd107374183;

	localparam logic [31:0] QUAKE_COOLDOWN = 32'd120000;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_JOLT_THR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MICRO_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_FACT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_JOLTS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_JOLT_WIN    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COINC_WIN   = 3'd7;

	localparam logic [15:0] RST_JOLT_THR    = 16'd400;
	localparam logic [15:0] RST_MICRO_THR   = 16'd150;
	localparam logic [7:0]  RST_SPIKE_FACT  = 8'd20;
	localparam logic [15:0] RST_NOISE_FLOOR = 16'd150;
	localparam logic [31:0] RST_COOLDOWN    = 32'd10000;
	localparam logic [4:0]  RST_MIN_JOLTS   = 5'd5;
	localparam logic [31:0] RST_JOLT_WIN    = 32'd5000;
	localparam logic [31:0] RST_COINC_WIN   = 32'd15000;

	typedef struct packed {
		logic [31:0] time_ms;
		logic [15:0] accel_mag;
		logic        noise_valid;
		logic [15:0] noise_rms;
	} in_item_t;

	typedef struct packed {
		logic        jolt_alert;
		logic        noise_alert;
		logic        quake_alert;
		logic        noise_spike;
		logic [15:0] accel_delta;
		logic [15:0] accel_avg;
		logic [15:0] noise_avg;
		logic [4:0]  recent_jolts;
		logic        vib_recent;
		logic        noise_recent;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic calc1;
		logic calc2;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
	} dp_status_t;

endpackage

// File: sv/vibration_noise_quake_detector_top.sv
// Each input transfer runs the steps load, calc1, calc2, scan of the k stored micro-jolt
// stamps (0..16) and finish; the reciprocal divide-by-5 runs beside the ring scan.
// A new item is accepted only in the idle step, after the previous one has finished.
// A waiting result holds the sequencer in its last step until the result transfer.
// Reset (arst_n low, asynchronous): baselines, timers, ring pointers and counts cleared,
// configuration registers at their defaults; ring contents are not cleared.
module vibration_noise_quake_detector_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [vnqd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vnqd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  vnqd_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output vnqd_pkg::out_item_t             out_data
);
	import vnqd_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	vnqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vnqd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

// File: sv/vnqd_ram.sv
module vnqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/vnqd_div5.sv
module vnqd_div5 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [vnqd_pkg::DIV_W-1:0] dividend,
	output logic [vnqd_pkg::DIV_W-1:0] quotient,
	output logic                       done
);
	import vnqd_pkg::*;

	logic [DIV_W-1:0]   dvd_q;
	logic [DIV_W-1:0]   quo_q;
	logic               busy_q;
	logic [2*DIV_W-1:0] prod;

	// capture on start, multiply by the reciprocal in the following cycle
	assign prod = (2*DIV_W)'(dvd_q) * (2*DIV_W)'(DIV_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
		end
		if (busy_q) begin
			quo_q <= DIV_W'(prod[2*DIV_W-1:DIV_SHIFT]);
		end
	end

	assign quotient = quo_q;
	assign done     = !busy_q;

endmodule

// File: sv/vnqd_dp.sv
module vnqd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [vnqd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vnqd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  vnqd_pkg::in_item_t              in_data,
	input  vnqd_pkg::ctrl_cmd_t             cmd,
	output vnqd_pkg::dp_status_t            sts,
	output vnqd_pkg::out_item_t             out_data
);
	import vnqd_pkg::*;

	function automatic logic [RING_AW-1:0] ring_prev(input logic [RING_AW-1:0] idx);
		return (idx == '0) ? RING_AW'(JOLT_SLOTS - 1) : idx - RING_AW'(1);
	endfunction

	function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
		return (idx == RING_AW'(JOLT_SLOTS - 1)) ? '0 : idx + RING_AW'(1);
	endfunction

	// configuration
	logic [15:0] jolt_thr_q, micro_thr_q, noise_floor_q;
	logic [7:0]  spike_fact_q;
	logic [4:0]  min_jolts_q;
	logic [31:0] cooldown_q, jolt_win_q, coinc_win_q;

	// current item
	logic [31:0] time_q;
	logic [15:0] mag_q, rms_q;
	logic        nvalid_q;

	// persistent state
	logic [BASE_W-1:0]  accel_avg_q, noise_avg_q;
	logic               accel_seeded_q, noise_seeded_q;
	logic [RING_AW-1:0] head_q;
	logic [CNT_W-1:0]   count_q;
	logic [31:0]        last_jolt_q, last_nalert_q, last_quake_q, last_spike_q, last_vib_q;

	// per-item working registers
	logic [BASE_W-1:0]  delta_q, prior_q;
	logic [31:0]        prod_q;
	logic [DIV_W-1:0]   adiv_q, ndiv_q;
	logic               jolt_al_q, noise_al_q, spike_q;
	logic [RING_AW-1:0] rd_idx_q;
	logic [CNT_W-1:0]   scan_left_q, recent_q;
	logic               hit_s1;
	out_item_t          out_q;

	logic [BASE_W-1:0]  m_val, r_val, abase, prior_d, delta_d;
	logic [28:0]        nsum;
	logic [31:0]        prod_d;
	logic               mag_nz, micro, jolt_al, spike, noise_al;
	logic [CNT_W-1:0]   count_inc;
	logic               rd_en;
	logic [31:0]        rd_data;
	logic [DIV_W-1:0]   aquo, nquo;
	logic               adone, ndone;
	logic               vib_now, noise_rec, vib_rec, quake;
	logic [31:0]        lv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jolt_thr_q    <= RST_JOLT_THR;
			micro_thr_q   <= RST_MICRO_THR;
			spike_fact_q  <= RST_SPIKE_FACT;
			noise_floor_q <= RST_NOISE_FLOOR;
			cooldown_q    <= RST_COOLDOWN;
			min_jolts_q   <= RST_MIN_JOLTS;
			jolt_win_q    <= RST_JOLT_WIN;
			coinc_win_q   <= RST_COINC_WIN;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_JOLT_THR:    jolt_thr_q    <= cfg_wdata[15:0];
				REG_MICRO_THR:   micro_thr_q   <= cfg_wdata[15:0];
				REG_SPIKE_FACT:  spike_fact_q  <= cfg_wdata[7:0];
				REG_NOISE_FLOOR: noise_floor_q <= cfg_wdata[15:0];
				REG_COOLDOWN:    cooldown_q    <= cfg_wdata;
				REG_MIN_JOLTS:   min_jolts_q   <= cfg_wdata[4:0];
				REG_JOLT_WIN:    jolt_win_q    <= cfg_wdata;
				REG_COINC_WIN:   coinc_win_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			time_q   <= in_data.time_ms;
			mag_q    <= in_data.accel_mag;
			nvalid_q <= in_data.noise_valid;
			rms_q    <= in_data.noise_rms;
		end
	end

	// first step: seeded baselines, deviation, dividends, spike product
	always_comb begin
		mag_nz  = (mag_q != '0);
		m_val   = {mag_q, 8'h00};
		r_val   = {rms_q, 8'h00};
		abase   = accel_seeded_q ? accel_avg_q : m_val;
		prior_d = noise_seeded_q ? noise_avg_q : r_val;
		if (!mag_nz) begin
			delta_d = '0;
		end else if (m_val > abase) begin
			delta_d = m_val - abase;
		end else begin
			delta_d = abase - m_val;
		end
		prod_d = {24'h0, spike_fact_q} * {8'h00, prior_d};
		// 19*prior + r, then /4 so the noise divide-by-5 gives /20
		nsum = 29'({prior_d, 4'h0}) + 29'({prior_d, 1'b0}) + 29'(prior_d) + 29'(r_val);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc1) begin
			delta_q <= delta_d;
			prior_q <= prior_d;
			prod_q  <= prod_d;
			adiv_q  <= DIV_W'({abase, 2'b00}) + DIV_W'(m_val);
			ndiv_q  <= nsum[28:2];
		end
	end

	// second step: alert and ring decisions
	always_comb begin
		jolt_al = mag_nz && (delta_q > {jolt_thr_q, 8'h00})
			&& ((time_q - last_jolt_q) > cooldown_q);
		micro = mag_nz && (delta_q > {micro_thr_q, 8'h00});
		spike = nvalid_q && (rms_q > noise_floor_q) && (prior_q > BASE_W'(256))
			&& ({8'h00, r_val} > prod_q);
		noise_al  = spike && ((time_q - last_nalert_q) > cooldown_q);
		count_inc = (count_q == CNT_W'(JOLT_SLOTS)) ? count_q : count_q + CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc2) begin
			jolt_al_q  <= jolt_al;
			spike_q    <= spike;
			noise_al_q <= noise_al;
		end
	end

	vnqd_ram #(
		.WIDTH (32),
		.DEPTH (JOLT_SLOTS)
	) u_ring (
		.clk     (clk),
		.wr_en   (cmd.calc2 && micro),
		.wr_addr (head_q),
		.wr_data (time_q),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	vnqd_div5 u_div_accel (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.calc2),
		.dividend (adiv_q),
		.quotient (aquo),
		.done     (adone)
	);

	vnqd_div5 u_div_noise (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.calc2),
		.dividend (ndiv_q),
		.quotient (nquo),
		.done     (ndone)
	);

	// ring scan: newest first, one read per cycle, compare on the registered data
	assign rd_en = cmd.scan && (scan_left_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			scan_left_q <= '0;
			recent_q    <= '0;
			hit_s1      <= 1'b0;
		end else begin
			hit_s1 <= rd_en;
			if (cmd.calc2) begin
				rd_idx_q    <= micro ? head_q : ring_prev(head_q);
				scan_left_q <= micro ? count_inc : count_q;
				recent_q    <= '0;
			end else begin
				if (rd_en) begin
					rd_idx_q    <= ring_prev(rd_idx_q);
					scan_left_q <= scan_left_q - CNT_W'(1);
				end
				if (hit_s1 && ((time_q - rd_data) <= jolt_win_q)) begin
					recent_q <= recent_q + CNT_W'(1);
				end
			end
		end
	end

	assign sts.scan_done = (scan_left_q == '0) && !hit_s1;
	assign sts.div_done  = adone && ndone;

	// final step: coincidence test
	always_comb begin
		vib_now   = (32'(recent_q) >= 32'(min_jolts_q));
		lv        = vib_now ? time_q : last_vib_q;
		noise_rec = (time_q - last_spike_q) <= coinc_win_q;
		vib_rec   = (time_q - lv) <= coinc_win_q;
		quake     = noise_rec && vib_rec && ((time_q - last_quake_q) > QUAKE_COOLDOWN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_avg_q    <= '0;
			noise_avg_q    <= '0;
			accel_seeded_q <= 1'b0;
			noise_seeded_q <= 1'b0;
			head_q         <= '0;
			count_q        <= '0;
			last_jolt_q    <= '0;
			last_nalert_q  <= '0;
			last_quake_q   <= '0;
			last_spike_q   <= '0;
			last_vib_q     <= '0;
		end else if (cmd.calc2) begin
			if (jolt_al) begin
				last_jolt_q <= time_q;
			end
			if (micro) begin
				head_q  <= ring_next(head_q);
				count_q <= count_inc;
			end
			if (spike) begin
				last_spike_q <= time_q;
			end
			if (noise_al) begin
				last_nalert_q <= time_q;
			end
		end else if (cmd.finish) begin
			if (mag_nz) begin
				accel_avg_q    <= aquo[BASE_W-1:0];
				accel_seeded_q <= 1'b1;
			end
			if (nvalid_q) begin
				noise_avg_q    <= nquo[BASE_W-1:0];
				noise_seeded_q <= 1'b1;
			end
			if (quake) begin
				last_quake_q <= time_q;
				last_spike_q <= '0;
				last_vib_q   <= '0;
				count_q      <= '0;
			end else begin
				last_vib_q <= lv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.jolt_alert   <= jolt_al_q;
			out_q.noise_alert  <= noise_al_q;
			out_q.quake_alert  <= quake;
			out_q.noise_spike  <= spike_q;
			out_q.accel_delta  <= delta_q[BASE_W-1:8];
			out_q.accel_avg    <= mag_nz ? aquo[BASE_W-1:8] : accel_avg_q[BASE_W-1:8];
			out_q.noise_avg    <= nvalid_q ? nquo[BASE_W-1:8] : noise_avg_q[BASE_W-1:8];
			out_q.recent_jolts <= 5'(recent_q);
			out_q.vib_recent   <= vib_rec;
			out_q.noise_recent <= noise_rec;
		end
	end

	assign out_data = out_q;

endmodule

// File: sv/vnqd_ctrl.sv
`include "vibration_noise_quake_detector_top_macros.svh"

module vnqd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  vnqd_pkg::dp_status_t sts,
	output vnqd_pkg::ctrl_cmd_t  cmd
);
	import vnqd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CALC1 = 3'd1;
	localparam logic [2:0] S_CALC2 = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_FINAL = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CALC1;
				end
			end
			S_CALC1: begin
				cmd.calc1 = 1'b1;
				state_d   = S_CALC2;
			end
			S_CALC2: begin
				cmd.calc2 = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done && sts.div_done) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				// result register must be free before it is reloaded
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`VNQD_ASSERT_NEXT(a_load_starts, cmd.load, state_q == S_CALC1)
	`VNQD_ASSERT_NEXT(a_div_started, state_q == S_CALC2, !sts.div_done)
	`VNQD_ASSERT_NEXT(a_final_holds, state_q == S_FINAL && out_valid_q && !out_ready, state_q == S_FINAL)
	`VNQD_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid_q && state_q == S_IDLE)

endmodule
